[design/lsct_pkg.sv]
`timescale 1ns / 1ps

package lsct_pkg;

  // Default sizing of the stack.
  localparam int unsigned LsctDepth   = 1024;
  localparam int unsigned LsctInitCap = 2;

  // Fixed widths of the beat fields.
  localparam int unsigned WordW  = 32;
  localparam int unsigned CountW = 11;

  // Operation codes carried by an input beat.
  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_PEEK = 2'd2,
    OP_NOP  = 2'd3
  } lsct_op_e;

  // Status codes reported with every result beat.
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_UNDERFLOW  = 2'd1,
    ST_PEEK_EMPTY = 2'd2,
    ST_OVERFLOW   = 2'd3
  } lsct_status_e;

  // Input beat.
  typedef struct packed {
    logic        [1:0]       operation;
    logic signed [WordW-1:0] push_value;
  } lsct_in_t;

  // Result beat.
  typedef struct packed {
    logic signed [WordW-1:0]  top_value;
    logic                     is_empty;
    logic        [CountW-1:0] item_count;
    logic        [CountW-1:0] logical_capacity;
    logic        [1:0]        status;
  } lsct_out_t;

  // Shift command broadcast along the cell row.
  typedef struct packed {
    logic push;
    logic pop;
  } lsct_shift_t;

endpackage

[design/lifo_stack_with_capacity_tracking.sv]
`timescale 1ns / 1ps

// LIFO stack of signed 32-bit words built as a row of DEPTH cells, with the
// top of stack always in the first cell. Every accepted push, pop or peek beat
// has its result beat registered in the output register; a new beat can be
// taken every cycle because the whole cell row shifts by one place per cycle,
// so the sustained rate is one beat per clock whenever the result side is not
// stalling. The result reports the top word (zero when empty), the empty flag,
// the entry count, the logical capacity (doubling, capped at DEPTH, on a push
// into a full capacity, halving to no less than two when a pop leaves it a
// quarter full) and a status code. A push into a completely full stack is
// dropped with overflow status. No clearing pass is needed after reset.
module lifo_stack_with_capacity_tracking #(
  parameter int unsigned DEPTH            = lsct_pkg::LsctDepth,
  parameter int unsigned INITIAL_CAPACITY = lsct_pkg::LsctInitCap
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  lsct_pkg::lsct_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output lsct_pkg::lsct_out_t out_data_o
);
  import lsct_pkg::*;

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic                    fire;
  lsct_shift_t             shift;
  lsct_status_e            status;
  logic [CntW-1:0]         count_d, cap_d, count_q, cap_q;
  logic signed [WordW-1:0] cell_data [DEPTH];
  logic signed [WordW-1:0] top_d;
  logic                    out_valid_q;
  lsct_out_t               out_data_q;

  // Input handshake: a held result blocks the input only while stalled.
  assign in_stall_o = out_valid_q && out_stall_i;
  assign fire       = in_valid_i && !in_stall_o;

  lsct_ctrl #(
    .DEPTH            (DEPTH),
    .INITIAL_CAPACITY (INITIAL_CAPACITY)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (fire),
    .operation_i (in_data_i.operation),
    .shift_o     (shift),
    .status_o    (status),
    .count_d_o   (count_d),
    .cap_d_o     (cap_d),
    .count_q_o   (count_q),
    .cap_q_o     (cap_q)
  );

  // Row of storage cells; the first takes the pushed word, the last takes
  // nothing meaningful on a pop since that slot is then beyond the count.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [WordW-1:0] above, below;
    if (i == 0) begin : g_first
      assign above = in_data_i.push_value;
    end else begin : g_mid_above
      assign above = cell_data[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign below = '0;
    end else begin : g_mid_below
      assign below = cell_data[i+1];
    end
    lsct_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (shift),
      .above_i (above),
      .below_i (below),
      .data_o  (cell_data[i])
    );
  end

  // Top word as it will stand after this beat.
  always_comb begin
    priority if (count_d == '0) begin
      top_d = '0;
    end else if (shift.push) begin
      top_d = in_data_i.push_value;
    end else if (shift.pop) begin
      top_d = cell_data[1];
    end else begin
      top_d = cell_data[0];
    end
  end

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_data_q.top_value        <= top_d;
      out_data_q.is_empty         <= (count_d == '0);
      out_data_q.item_count       <= CountW'(count_d);
      out_data_q.logical_capacity <= CountW'(cap_d);
      out_data_q.status           <= status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Every accepted beat produces a result beat in the next cycle.
  a_fire_to_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_o)
    else $error("accepted beat did not produce a result");

  // The count never runs past the logical capacity.
  a_count_in_cap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= cap_q)
    else $error("entry count exceeds logical capacity");

  // A push that is kept shows its word on top in the result.
  a_push_on_top : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && shift.push) |=> (out_data_o.top_value == $past(in_data_i.push_value)))
    else $error("pushed word is not on top");

endmodule

[design/lsct_cell.sv]
`timescale 1ns / 1ps

module lsct_cell (
  input  logic                                 clk_i,
  input  lsct_pkg::lsct_shift_t                shift_i,
  input  logic signed [lsct_pkg::WordW-1:0]    above_i,
  input  logic signed [lsct_pkg::WordW-1:0]    below_i,
  output logic signed [lsct_pkg::WordW-1:0]    data_o
);
  import lsct_pkg::*;

  logic signed [WordW-1:0] data_q;

  // A push moves every entry one cell deeper, a pop one cell toward the top.
  // With neither, the cell holds its word.
  always_ff @(posedge clk_i) begin
    if (shift_i.push) begin
      data_q <= above_i;
    end else if (shift_i.pop) begin
      data_q <= below_i;
    end
  end

  assign data_o = data_q;

endmodule

[design/lsct_ctrl.sv]
`timescale 1ns / 1ps

module lsct_ctrl #(
  parameter int unsigned DEPTH            = lsct_pkg::LsctDepth,
  parameter int unsigned INITIAL_CAPACITY = lsct_pkg::LsctInitCap,
  localparam int unsigned CntW            = $clog2(DEPTH + 1)
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     fire_i,
  input  logic [1:0]               operation_i,
  output lsct_pkg::lsct_shift_t    shift_o,
  output lsct_pkg::lsct_status_e   status_o,
  output logic [CntW-1:0]          count_d_o,
  output logic [CntW-1:0]          cap_d_o,
  output logic [CntW-1:0]          count_q_o,
  output logic [CntW-1:0]          cap_q_o
);
  import lsct_pkg::*;

  localparam logic [CntW-1:0] DepthC   = CntW'(DEPTH);
  localparam logic [CntW:0]   DepthX   = (CntW + 1)'(DEPTH);
  localparam logic [CntW-1:0] InitCapC = CntW'(INITIAL_CAPACITY);
  localparam logic [CntW-1:0] MinCapC  = CntW'(2);

  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] cap_q, cap_d;
  logic [CntW:0]   cap_dbl;
  lsct_op_e        op;

  assign op      = lsct_op_e'(operation_i);
  assign cap_dbl = {cap_q, 1'b0};

  // Count and capacity rules for one accepted beat.
  always_comb begin
    count_d  = count_q;
    cap_d    = cap_q;
    status_o = ST_OK;
    shift_o  = '0;
    if (fire_i) begin
      unique case (op)
        OP_PUSH: begin
          if (count_q == DepthC) begin
            status_o = ST_OVERFLOW;
          end else begin
            shift_o.push = 1'b1;
            count_d      = count_q + CntW'(1);
            if (count_q >= cap_q) begin
              cap_d = (cap_dbl > DepthX) ? DepthC : cap_dbl[CntW-1:0];
            end
          end
        end
        OP_POP: begin
          if (count_q == '0) begin
            status_o = ST_UNDERFLOW;
          end else begin
            shift_o.pop = 1'b1;
            count_d     = count_q - CntW'(1);
            if ((count_d != '0) && (count_d == (cap_q >> 2)) &&
                ((cap_q >> 1) >= MinCapC)) begin
              cap_d = cap_q >> 1;
            end
          end
        end
        OP_PEEK: begin
          if (count_q == '0) begin
            status_o = ST_PEEK_EMPTY;
          end
        end
        OP_NOP: begin
        end
        default: begin
        end
      endcase
    end
  end

  // Entry count and logical capacity.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      cap_q   <= InitCapC;
    end else begin
      count_q <= count_d;
      cap_q   <= cap_d;
    end
  end

  assign count_d_o = count_d;
  assign cap_d_o   = cap_d;
  assign count_q_o = count_q;
  assign cap_q_o   = cap_q;

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
  import lsct_pkg::*;

  localparam int unsigned StackDepth = LsctDepth;
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned RandBeats  = 75;
  localparam int unsigned FillBeats  = 64;

  // Idle and stall percentages of the random phases.
  localparam int PhaseIdle[4]  = '{0, 84, 0, 37};
  localparam int PhaseStall[4] = '{0, 0, 84, 37};

  typedef struct {
    lsct_in_t  beat;
    bit        typed;
    lsct_out_t want;
  } dir_row_t;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  lsct_in_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  lsct_out_t out_data_o;

  // Expectation typed into the directed table, carried alongside the beat.
  bit        beat_typed = 1'b0;
  lsct_out_t beat_want  = '0;

  // Predictor state.
  logic [WordW-1:0] shadow_words[StackDepth];
  int unsigned      shadow_held = 0;
  int unsigned      shadow_cap  = LsctInitCap;

  lsct_out_t   pending_views[$];
  dir_row_t    dir_rows[$];
  int          stall_pct    = 0;
  int unsigned errors       = 0;
  int unsigned beats_taken  = 0;
  int unsigned views_seen   = 0;
  int unsigned deepest      = 0;
  int unsigned dropped      = 0;
  int unsigned cycles       = 0;

  lifo_stack_with_capacity_tracking dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Applies one beat to the shadow stack and returns the view it should report.
  function automatic lsct_out_t next_stack_view(lsct_in_t beat);
    lsct_out_t    view;
    lsct_status_e st;
    st = ST_OK;
    case (lsct_op_e'(beat.operation))
      OP_PUSH: begin
        if (shadow_held == StackDepth) begin
          st = ST_OVERFLOW;
          dropped++;
        end else begin
          if (shadow_held >= shadow_cap)
            shadow_cap = (shadow_cap * 2 > StackDepth) ? StackDepth : shadow_cap * 2;
          shadow_words[shadow_held] = beat.push_value;
          shadow_held++;
        end
      end
      OP_POP: begin
        if (shadow_held == 0) begin
          st = ST_UNDERFLOW;
        end else begin
          shadow_held--;
          // Shrink once the stack drops to a quarter, never below two.
          if (shadow_held > 0 && shadow_held == shadow_cap / 4 && shadow_cap / 2 >= 2)
            shadow_cap = shadow_cap / 2;
        end
      end
      OP_PEEK: begin
        if (shadow_held == 0) st = ST_PEEK_EMPTY;
      end
      default: ;
    endcase
    if (shadow_held > deepest) deepest = shadow_held;
    view.top_value        = (shadow_held > 0) ? shadow_words[shadow_held-1] : '0;
    view.is_empty         = (shadow_held == 0);
    view.item_count       = shadow_held[CountW-1:0];
    view.logical_capacity = shadow_cap[CountW-1:0];
    view.status           = st;
    return view;
  endfunction

  function automatic lsct_out_t mk_view(logic [WordW-1:0] top, logic empty,
                                        int unsigned held, int unsigned cap,
                                        lsct_status_e st);
    lsct_out_t view;
    view.top_value        = top;
    view.is_empty         = empty;
    view.item_count       = held[CountW-1:0];
    view.logical_capacity = cap[CountW-1:0];
    view.status           = st;
    return view;
  endfunction

  task automatic add_row(lsct_op_e op, logic [WordW-1:0] value, bit typed,
                         lsct_out_t want);
    dir_row_t row;
    row.beat.operation  = op;
    row.beat.push_value = value;
    row.typed           = typed;
    row.want            = want;
    dir_rows.push_back(row);
  endtask

  // Random operation with content biased toward the signed extremes.
  function automatic lsct_in_t rand_beat();
    lsct_in_t    beat;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 42)      beat.operation = OP_PUSH;
    else if (pick < 77) beat.operation = OP_POP;
    else if (pick < 92) beat.operation = OP_PEEK;
    else                beat.operation = OP_NOP;
    case ($urandom_range(7))
      0:       beat.push_value = 32'h7FFF_FFFF;
      1:       beat.push_value = 32'h8000_0000;
      2:       beat.push_value = 32'h0000_0000;
      3:       beat.push_value = 32'hFFFF_FFFF;
      default: beat.push_value = $urandom;
    endcase
    return beat;
  endfunction

  // Drives one beat from the falling edge and holds it until accepted.
  task automatic send_beat(lsct_in_t beat, bit typed, lsct_out_t want, int idle_pct);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    beat_typed <= typed;
    beat_want  <= want;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Stops sending and waits until every expected result has come back.
  task automatic wait_drained();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_views.size() != 0) @(posedge clk_i);
  endtask

  // Result side back-pressure.
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // Predicts on every accepted input beat and checks every accepted result beat.
  always @(posedge clk_i) begin
    lsct_out_t pred;
    lsct_out_t want;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        pred = next_stack_view(in_data_i);
        pending_views.push_back(beat_typed ? beat_want : pred);
        beats_taken++;
      end
      if (out_valid_o && !out_stall_i) begin
        views_seen++;
        if (pending_views.size() == 0) begin
          $error("result beat with no expectation pending");
          errors++;
        end else begin
          want = pending_views.pop_front();
          if (out_data_o.top_value !== want.top_value) begin
            $error("top_value: expected %0d, got %0d", want.top_value, out_data_o.top_value);
            errors++;
          end
          if (out_data_o.is_empty !== want.is_empty) begin
            $error("is_empty: expected %0d, got %0d", want.is_empty, out_data_o.is_empty);
            errors++;
          end
          if (out_data_o.item_count !== want.item_count) begin
            $error("item_count: expected %0d, got %0d", want.item_count,
                   out_data_o.item_count);
            errors++;
          end
          if (out_data_o.logical_capacity !== want.logical_capacity) begin
            $error("logical_capacity: expected %0d, got %0d", want.logical_capacity,
                   out_data_o.logical_capacity);
            errors++;
          end
          if (out_data_o.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data_o.status);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_views.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    lsct_out_t   none;
    int unsigned n;
    none = '0;

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed table: empty-stack errors, signed extremes, growth and shrink.
    add_row(OP_POP,  32'h0, 1'b1, mk_view(32'h0, 1'b1, 0, 2, ST_UNDERFLOW));
    add_row(OP_PEEK, 32'h0, 1'b1, mk_view(32'h0, 1'b1, 0, 2, ST_PEEK_EMPTY));
    add_row(OP_NOP,  32'hFFFF_FFFF, 1'b1, mk_view(32'h0, 1'b1, 0, 2, ST_OK));
    add_row(OP_PUSH, 32'h7FFF_FFFF, 1'b1, mk_view(32'h7FFF_FFFF, 1'b0, 1, 2, ST_OK));
    add_row(OP_PUSH, 32'h8000_0000, 1'b1, mk_view(32'h8000_0000, 1'b0, 2, 2, ST_OK));
    add_row(OP_PUSH, 32'h0000_0000, 1'b0, none);
    add_row(OP_PUSH, 32'hFFFF_FFFF, 1'b0, none);
    add_row(OP_PUSH, 32'h0000_0001, 1'b0, none);
    add_row(OP_PEEK, 32'h1234_5678, 1'b0, none);
    add_row(OP_NOP,  32'h0, 1'b0, none);
    repeat (5) add_row(OP_POP, 32'h0, 1'b0, none);
    add_row(OP_POP,  32'hFFFF_FFFF, 1'b1, mk_view(32'h0, 1'b1, 0, 2, ST_UNDERFLOW));
    add_row(OP_PUSH, 32'h5555_5555, 1'b0, none);
    add_row(OP_PUSH, 32'hAAAA_AAAA, 1'b0, none);
    add_row(OP_POP,  32'h0, 1'b0, none);
    add_row(OP_POP,  32'h0, 1'b0, none);
    add_row(OP_PEEK, 32'h0, 1'b1, mk_view(32'h0, 1'b1, 0, 2, ST_PEEK_EMPTY));
    foreach (dir_rows[i]) send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want, 0);
    wait_drained();

    // Random phases, each ending with the sender holding off until all results are in.
    for (int phase = 0; phase < 4; phase++) begin
      stall_pct = PhaseStall[phase];
      for (n = 0; n < RandBeats; n++) send_beat(rand_beat(), 1'b0, none, PhaseIdle[phase]);
      // Last phase also builds a deep stack, then pops two more entries than it pushed.
      if (phase == 3) begin
        for (n = 0; n < FillBeats; n++) begin
          send_beat('{operation: OP_PUSH, push_value: $urandom}, 1'b0, none,
                    PhaseIdle[phase]);
        end
        send_beat('{operation: OP_PEEK, push_value: 32'h0}, 1'b0, none, PhaseIdle[phase]);
        for (n = 0; n < FillBeats + 2; n++) begin
          send_beat('{operation: OP_POP, push_value: $urandom}, 1'b0, none,
                    PhaseIdle[phase]);
        end
      end
      wait_drained();
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait_drained();
    repeat (20) @(posedge clk_i);

    $display("stimulus: %0d beats over directed and four random phases, %0d results checked",
             beats_taken, views_seen);
    $display("deepest stack %0d entries, %0d pushes dropped at full depth", deepest, dropped);
    if (errors == 0 && pending_views.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
